/* rtl/i2da_pkg.sv */
// ----------------------------------------------------------------------------
// i2da_pkg: shared definitions of the decimal text unit
// defaults, character codes and the back end sequencer states
// ----------------------------------------------------------------------------
package i2da_pkg;

	// default converted width and front-to-back queue depth
	localparam int VALUE_WIDTH_DEF = 64;
	localparam int QUEUE_DEPTH_DEF = 2;

	// width of the input value field and of one output character
	localparam int IN_WIDTH   = 64;
	localparam int CHAR_WIDTH = 6;

	// ascii codes, cut to the character width
	localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO  = 6'd48;
	localparam logic [CHAR_WIDTH-1:0] CHAR_MINUS = 6'd45;

	// back end sequencer
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CONV,
		ST_SIGN,
		ST_EMIT
	} back_state_t;

endpackage

/* rtl/i2da_if.sv */
// ----------------------------------------------------------------------------
// i2da_if: valid/ready channels of the decimal text unit
// input channel carries a binary value, output channel one character per beat
// ----------------------------------------------------------------------------
interface i2da_in_if;
	logic                          valid;
	logic                          ready;
	logic [i2da_pkg::IN_WIDTH-1:0] value;
	logic                          is_signed;

	modport source (output valid, output value, output is_signed, input ready);
	modport sink   (input valid, input value, input is_signed, output ready);
endinterface

interface i2da_out_if;
	logic                            valid;
	logic                            ready;
	logic [i2da_pkg::CHAR_WIDTH-1:0] character;
	logic                            last;

	modport source (output valid, output character, output last, input ready);
	modport sink   (input valid, input character, input last, output ready);
endinterface

/* rtl/i2da_front.sv */
// ----------------------------------------------------------------------------
// i2da_front: input side of the decimal text unit
// trims the value to width, decides the sign and forms the magnitude
// ----------------------------------------------------------------------------
module i2da_front #(
	parameter int VALUE_WIDTH = i2da_pkg::VALUE_WIDTH_DEF
) (
	i2da_in_if.sink            item,
	output logic               push_valid,
	input  logic               push_ready,
	output logic [VALUE_WIDTH:0] push_data
);

	logic [VALUE_WIDTH-1:0] v;
	logic [VALUE_WIDTH-1:0] mag;
	logic                   neg;

	always_comb begin
		v   = item.value[VALUE_WIDTH-1:0];
		neg = item.is_signed & v[VALUE_WIDTH-1];
		// two's complement negate, most negative value wraps to its own magnitude
		mag = neg ? (~v + VALUE_WIDTH'(1)) : v;
	end

	assign push_valid = item.valid;
	assign push_data  = {neg, mag};
	assign item.ready = push_ready;

endmodule

/* rtl/i2da_fifo.sv */
// ----------------------------------------------------------------------------
// i2da_fifo: short queue between front and back
// power-of-two depth, registered entries, pointer based
// ----------------------------------------------------------------------------
module i2da_fifo #(
	parameter int WIDTH = i2da_pkg::VALUE_WIDTH_DEF + 1,
	parameter int DEPTH = i2da_pkg::QUEUE_DEPTH_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push_valid,
	output logic             push_ready,
	input  logic [WIDTH-1:0] push_data,
	output logic             pop_valid,
	input  logic             pop_ready,
	output logic [WIDTH-1:0] pop_data
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    cnt_q;
	logic             push;
	logic             pop;

	assign push_ready = (cnt_q != CW'(DEPTH));
	assign pop_valid  = (cnt_q != '0);
	assign pop_data   = mem_q[rd_ptr_q];
	assign push       = push_valid & push_ready;
	assign pop        = pop_valid & pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CW'(1);
			end
		end
	end

endmodule

/* rtl/i2da_back.sv */
// ----------------------------------------------------------------------------
// i2da_back: conversion and character output
// shift-add-3 binary to bcd, a bit per cycle, then a digit per unstalled cycle
// ----------------------------------------------------------------------------
module i2da_back #(
	parameter int VALUE_WIDTH = i2da_pkg::VALUE_WIDTH_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 pop_valid,
	output logic                 pop_ready,
	input  logic [VALUE_WIDTH:0] pop_data,
	i2da_out_if.source           text
);

	// decimal digits of the largest magnitude, floor(w*log10(2)) + 1
	localparam int NDIG = (VALUE_WIDTH * 1233) / 4096 + 1;
	localparam int BW   = NDIG * 4;
	localparam int IW   = $clog2(VALUE_WIDTH);
	localparam int DW   = $clog2(NDIG + 1);

	i2da_pkg::back_state_t state_q, state_d;

	logic [VALUE_WIDTH-1:0] mag_q;
	logic [BW-1:0]          bcd_q;
	logic [BW-1:0]          adj;
	logic [3:0]             nib;
	logic [3:0]             top;
	logic [IW-1:0]          iter_q;
	logic [DW-1:0]          dig_q;
	logic                   neg_q;
	logic                   started_q;
	logic                   ovalid_q;
	logic [i2da_pkg::CHAR_WIDTH-1:0] ochar_q;
	logic                   olast_q;

	logic out_free;
	logic load;
	logic conv;
	logic sign_fire;
	logic skip;
	logic emit_fire;

	assign out_free = !ovalid_q || text.ready;
	assign top      = bcd_q[BW-1 -: 4];

	// add 3 to every digit of five or more ahead of the shift
	always_comb begin
		adj = '0;
		nib = '0;
		for (int i = 0; i < NDIG; i++) begin
			nib = bcd_q[i*4 +: 4];
			adj[i*4 +: 4] = (nib >= 4'd5) ? nib + 4'd3 : nib;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			i2da_pkg::ST_IDLE: begin
				if (pop_valid) begin
					state_d = i2da_pkg::ST_CONV;
				end
			end
			i2da_pkg::ST_CONV: begin
				if (iter_q == '0) begin
					state_d = neg_q ? i2da_pkg::ST_SIGN : i2da_pkg::ST_EMIT;
				end
			end
			i2da_pkg::ST_SIGN: begin
				if (out_free) begin
					state_d = i2da_pkg::ST_EMIT;
				end
			end
			i2da_pkg::ST_EMIT: begin
				if (emit_fire && dig_q == DW'(1)) begin
					state_d = i2da_pkg::ST_IDLE;
				end
			end
			default: state_d = i2da_pkg::ST_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		load      = 1'b0;
		conv      = 1'b0;
		sign_fire = 1'b0;
		skip      = 1'b0;
		emit_fire = 1'b0;
		unique case (state_q)
			i2da_pkg::ST_IDLE: load      = pop_valid;
			i2da_pkg::ST_CONV: conv      = 1'b1;
			i2da_pkg::ST_SIGN: sign_fire = out_free;
			i2da_pkg::ST_EMIT: begin
				// leading zeros drop out without a beat, the last digit always goes
				skip      = !started_q && (top == 4'd0) && (dig_q > DW'(1));
				emit_fire = !skip && out_free;
			end
			default: ;
		endcase
	end

	assign pop_ready = (state_q == i2da_pkg::ST_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= i2da_pkg::ST_IDLE;
			iter_q    <= '0;
			dig_q     <= '0;
			neg_q     <= 1'b0;
			started_q <= 1'b0;
			ovalid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (load) begin
				iter_q    <= IW'(VALUE_WIDTH - 1);
				dig_q     <= DW'(NDIG);
				neg_q     <= pop_data[VALUE_WIDTH];
				started_q <= 1'b0;
			end
			if (conv) begin
				iter_q <= iter_q - IW'(1);
			end
			if (emit_fire) begin
				dig_q     <= dig_q - DW'(1);
				started_q <= 1'b1;
			end else if (skip) begin
				dig_q <= dig_q - DW'(1);
			end
			if (sign_fire || emit_fire) begin
				ovalid_q <= 1'b1;
			end else if (text.ready) begin
				ovalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			mag_q <= pop_data[VALUE_WIDTH-1:0];
			bcd_q <= '0;
		end else if (conv) begin
			bcd_q <= {adj[BW-2:0], mag_q[VALUE_WIDTH-1]};
			mag_q <= mag_q << 1;
		end else if (skip || emit_fire) begin
			bcd_q <= {bcd_q[BW-5:0], 4'd0};
		end
		if (sign_fire) begin
			ochar_q <= i2da_pkg::CHAR_MINUS;
			olast_q <= 1'b0;
		end else if (emit_fire) begin
			ochar_q <= i2da_pkg::CHAR_ZERO + {2'b00, top};
			olast_q <= (dig_q == DW'(1));
		end
	end

	assign text.valid     = ovalid_q;
	assign text.character = ochar_q;
	assign text.last      = olast_q;

`ifndef SYNTHESIS
	a_iter_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == i2da_pkg::ST_CONV && iter_q != '0) |=> iter_q == $past(iter_q) - IW'(1))
		else $error("conversion counter did not step");

	a_emit_digits_left: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == i2da_pkg::ST_EMIT) |-> (dig_q != '0))
		else $error("emitting with no digits left");

	a_skip_only_leading: assert property (@(posedge clk) disable iff (!arst_n)
		skip |-> !started_q)
		else $error("zero dropped after first digit");

	a_last_ends_item: assert property (@(posedge clk) disable iff (!arst_n)
		(emit_fire && dig_q == DW'(1)) |=> (state_q == i2da_pkg::ST_IDLE && olast_q && ovalid_q))
		else $error("final digit did not close the item");
`endif

endmodule

/* rtl/integer_to_decimal_ascii_unit.sv */
// ----------------------------------------------------------------------------
// integer_to_decimal_ascii_unit: binary integer to decimal ascii text
// one value in, its decimal characters out one beat each, last one marked
// ----------------------------------------------------------------------------
// flow: on an idle unit a value passes the queue, is loaded by the sequencer,
//   runs the bit-serial bcd loop, then the minus or first kept digit is registered
// throughput: the next value is loaded once the last digit of the one before is
//   registered; the bcd loop, a minus slot if negative, then NDIG digit slots
//   (20 at 64 bits), one per cycle unless the output stalls, dropped zeros included
// reset: arst_n clears the queue, the sequencer and the output register
// ----------------------------------------------------------------------------
module integer_to_decimal_ascii_unit #(
	parameter int VALUE_WIDTH = i2da_pkg::VALUE_WIDTH_DEF,
	parameter int QUEUE_DEPTH = i2da_pkg::QUEUE_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	i2da_in_if.sink    item,
	i2da_out_if.source text
);

	// queue entry: sign flag over the magnitude
	logic                 push_valid;
	logic                 push_ready;
	logic [VALUE_WIDTH:0] push_data;
	logic                 pop_valid;
	logic                 pop_ready;
	logic [VALUE_WIDTH:0] pop_data;

	// front: width trim, sign decision and negate, no storage of its own
	i2da_front #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_front (
		.item      (item),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data (push_data)
	);

	// queue lets the input side keep taking beats while the back end converts
	i2da_fifo #(
		.WIDTH(VALUE_WIDTH + 1),
		.DEPTH(QUEUE_DEPTH)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_valid(push_valid),
		.push_ready(push_ready),
		.push_data (push_data),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_data  (pop_data)
	);

	// back: bcd conversion, optional minus, digits most significant first
	// the output register parts the sequencer from the downstream stall
	i2da_back #(
		.VALUE_WIDTH(VALUE_WIDTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.pop_valid(pop_valid),
		.pop_ready(pop_ready),
		.pop_data (pop_data),
		.text     (text)
	);

endmodule
